/* hw/rtl/sva_pkg.sv */
// shared types and constants for the synth voice allocator
package sva_pkg;

  localparam int NUM_VOICES = 8;
  localparam int VIDX_W     = $clog2(NUM_VOICES);
  localparam int CNT_W      = $clog2(NUM_VOICES + 1);
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int AGE_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MONO_LEGATO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    FUNC_NOTE_ON    = 2'd0,
    FUNC_NOTE_OFF   = 2'd1,
    FUNC_ALL_OFF    = 2'd2,
    FUNC_VOICE_DONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_TRIGGER = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_SNAP    = 2'd2,
    ACT_GLIDE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEAL,
    ST_POLY_EMIT,
    ST_REL_SCAN,
    ST_MONO_REM,
    ST_MONO_ON,
    ST_MONO_OFF
  } state_t;

endpackage

/* hw/rtl/sva_in_if.sv */
// note event channel
interface sva_in_if;
  import sva_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [NOTE_W-1:0]       note;
  logic [VEL_W-1:0]        velocity;
  logic [2:0]              voice_index;

  modport source (output valid, func, note, velocity, voice_index, input ready);
  modport sink   (input valid, func, note, velocity, voice_index, output ready);
endinterface

/* hw/rtl/sva_out_if.sv */
// voice command channel
interface sva_out_if;
  import sva_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [2:0]              voice;
  logic [NOTE_W-1:0]       note_out;
  logic [VEL_W-1:0]        velocity_out;
  logic                    last;

  modport source (output valid, action, voice, note_out, velocity_out, last, input ready);
  modport sink   (input valid, action, voice, note_out, velocity_out, last, output ready);
endinterface

/* hw/rtl/synth_voice_allocator_unit.sv */
// voice allocator: note events in, voice commands out, one event at a time
// poly note on triggers a free voice directly, or with none free first runs a steal search over
//   voices 2..7 through one age comparator; mono note on drops the note from the stack, then emits;
//   note off and all notes off scan one voice per cycle unless a hit waits on the output, and note off
//   then updates the mono stack when it is in use; in ready low while busy, so a new event waits
// reset: synchronous active low; clears state, busy bits, stack count, age, regs, out valid
module synth_voice_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  sva_in_if.sink                            in_ch,
  sva_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [sva_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sva_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sva_pkg::*;

  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(NUM_VOICES - 1);

  // control state
  state_t                  state_r, state_nxt;
  logic                    mono_legato_r, glide_enable_r;
  logic [NUM_VOICES-1:0]   voice_busy_r, voice_busy_nxt;
  logic [AGE_W-1:0]        next_age_r, next_age_nxt;
  logic [CNT_W-1:0]        held_count_r, held_count_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // payload state
  logic [NOTE_W-1:0]       voice_note_r [NUM_VOICES];
  logic [NOTE_W-1:0]       voice_note_nxt [NUM_VOICES];
  logic [AGE_W-1:0]        voice_age_r [NUM_VOICES];
  logic [AGE_W-1:0]        voice_age_nxt [NUM_VOICES];
  logic [NOTE_W-1:0]       held_stack_r [NUM_VOICES];
  logic [NOTE_W-1:0]       held_stack_nxt [NUM_VOICES];
  logic [VEL_W-1:0]        mono_vel_r, mono_vel_nxt;

  // per-event work registers
  func_t                   func_r, func_nxt;
  logic [NOTE_W-1:0]       note_r, note_nxt;
  logic [VEL_W-1:0]        vel_r, vel_nxt;
  logic [VIDX_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [VIDX_W-1:0]       pick_r, pick_nxt;
  logic [AGE_W-1:0]        best_age_r, best_age_nxt;
  logic [NUM_VOICES-1:0]   mask_r, mask_nxt;
  logic                    mono_tail_r, mono_tail_nxt;
  logic                    mono_emit_r, mono_emit_nxt;
  logic                    was_empty_r, was_empty_nxt;

  // output register
  action_t                 out_action_r;
  logic [VIDX_W-1:0]       out_voice_r;
  logic [NOTE_W-1:0]       out_note_r;
  logic [VEL_W-1:0]        out_vel_r;
  logic                    out_last_r;

  // emit request from the sequencer
  logic                    emit;
  action_t                 emit_action;
  logic [VIDX_W-1:0]       emit_voice;
  logic [NOTE_W-1:0]       emit_note;
  logic [VEL_W-1:0]        emit_vel;
  logic                    emit_last;

  logic                    in_fire, can_emit;
  func_t                   in_func;
  logic                    any_free;
  logic [VIDX_W-1:0]       first_free;
  logic [NUM_VOICES-1:0]   off_match;
  logic                    rem_found;
  logic [VIDX_W-1:0]       rem_idx;
  logic                    scan_hit, scan_more;
  logic [NUM_VOICES-1:0]   scan_rem;
  logic                    age_less;
  logic [NOTE_W-1:0]       stack_top;
  logic                    note0_hit;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign can_emit    = !out_valid_r || out_ch.ready;

  // zero-velocity note on counts as note off
  always_comb begin
    in_func = func_t'(in_ch.func);
    if (in_func == FUNC_NOTE_ON && in_ch.velocity == '0) begin
      in_func = FUNC_NOTE_OFF;
    end
  end

  // first free voice from 1 upward
  always_comb begin
    any_free   = 1'b0;
    first_free = '0;
    for (int i = NUM_VOICES - 1; i >= 1; i--) begin
      if (!voice_busy_r[i]) begin
        any_free   = 1'b1;
        first_free = VIDX_W'(i);
      end
    end
  end

  // busy voices above 0 that hold the incoming note
  always_comb begin
    off_match = '0;
    for (int i = 1; i < NUM_VOICES; i++) begin
      off_match[i] = voice_busy_r[i] && (voice_note_r[i] == in_ch.note);
    end
  end

  // first stack entry holding the current note
  always_comb begin
    rem_found = 1'b0;
    rem_idx   = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < held_count_r) && (held_stack_r[i] == note_r)) begin
        rem_found = 1'b1;
        rem_idx   = VIDX_W'(i);
      end
    end
  end

  // shared age comparator and scan helpers
  assign age_less  = voice_age_r[scan_idx_r] < best_age_r;
  assign scan_hit  = mask_r[scan_idx_r];
  assign scan_rem  = mask_r >> scan_idx_r;
  assign scan_more = |scan_rem[NUM_VOICES-1:1];
  assign stack_top = held_stack_r[VIDX_W'(held_count_r - CNT_W'(1))];
  assign note0_hit = (voice_note_r[0] == note_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_func)
            FUNC_NOTE_ON: begin
              if (mono_legato_r) begin
                state_nxt = ST_MONO_REM;
              end else if (any_free) begin
                state_nxt = ST_POLY_EMIT;
              end else begin
                state_nxt = ST_STEAL;
              end
            end
            FUNC_NOTE_OFF, FUNC_ALL_OFF: state_nxt = ST_REL_SCAN;
            FUNC_VOICE_DONE:             state_nxt = ST_IDLE;
            default:                     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_STEAL: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_POLY_EMIT;
        end
      end
      ST_POLY_EMIT: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REL_SCAN: begin
        if ((!scan_hit || can_emit) && scan_idx_r == LAST_IDX) begin
          state_nxt = mono_tail_r ? ST_MONO_REM : ST_IDLE;
        end
      end
      ST_MONO_REM: begin
        state_nxt = (func_r == FUNC_NOTE_ON) ? ST_MONO_ON : ST_MONO_OFF;
      end
      ST_MONO_ON: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MONO_OFF: begin
        if (!note0_hit || can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and command generation
  always_comb begin
    voice_busy_nxt = voice_busy_r;
    next_age_nxt   = next_age_r;
    held_count_nxt = held_count_r;
    voice_note_nxt = voice_note_r;
    voice_age_nxt  = voice_age_r;
    held_stack_nxt = held_stack_r;
    mono_vel_nxt   = mono_vel_r;
    func_nxt       = func_r;
    note_nxt       = note_r;
    vel_nxt        = vel_r;
    scan_idx_nxt   = scan_idx_r;
    pick_nxt       = pick_r;
    best_age_nxt   = best_age_r;
    mask_nxt       = mask_r;
    mono_tail_nxt  = mono_tail_r;
    mono_emit_nxt  = mono_emit_r;
    was_empty_nxt  = was_empty_r;
    emit           = 1'b0;
    emit_action    = ACT_TRIGGER;
    emit_voice     = '0;
    emit_note      = '0;
    emit_vel       = '0;
    emit_last      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt      = in_func;
          note_nxt      = in_ch.note;
          vel_nxt       = in_ch.velocity;
          scan_idx_nxt  = '0;
          was_empty_nxt = (held_count_r == '0);
          mono_tail_nxt = 1'b0;
          mono_emit_nxt = 1'b0;
          unique case (in_func)
            FUNC_NOTE_ON: begin
              // steal search starts from voice 1
              pick_nxt     = any_free ? first_free : VIDX_W'(1);
              best_age_nxt = voice_age_r[1];
              scan_idx_nxt = VIDX_W'(2);
            end
            FUNC_NOTE_OFF: begin
              mask_nxt      = off_match;
              mono_tail_nxt = (held_count_r != '0) ||
                              (voice_busy_r[0] && voice_note_r[0] == in_ch.note);
              mono_emit_nxt = (voice_note_r[0] == in_ch.note) &&
                              ((held_count_r != '0) || voice_busy_r[0]);
            end
            FUNC_ALL_OFF: begin
              mask_nxt       = voice_busy_r;
              held_count_nxt = '0;
            end
            FUNC_VOICE_DONE: begin
              if (32'(in_ch.voice_index) < NUM_VOICES) begin
                voice_busy_nxt[VIDX_W'(in_ch.voice_index)] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      // oldest voice search, one voice per cycle
      ST_STEAL: begin
        if (age_less) begin
          pick_nxt     = scan_idx_r;
          best_age_nxt = voice_age_r[scan_idx_r];
        end
        scan_idx_nxt = scan_idx_r + VIDX_W'(1);
      end

      ST_POLY_EMIT: begin
        emit_action = ACT_TRIGGER;
        emit_voice  = pick_r;
        emit_note   = note_r;
        emit_vel    = vel_r;
        if (can_emit) begin
          emit                     = 1'b1;
          voice_busy_nxt[pick_r]   = 1'b1;
          voice_note_nxt[pick_r]   = note_r;
          voice_age_nxt[pick_r]    = next_age_r;
          next_age_nxt             = next_age_r + AGE_W'(1);
        end
      end

      // release scan, one voice per cycle unless a hit waits on the output
      ST_REL_SCAN: begin
        emit_action = ACT_RELEASE;
        emit_voice  = scan_idx_r;
        emit_last   = !scan_more && !mono_emit_r;
        if (scan_hit) begin
          emit = can_emit;
        end
        if (!scan_hit || can_emit) begin
          scan_idx_nxt = scan_idx_r + VIDX_W'(1);
        end
      end

      // drop the note from the held stack
      ST_MONO_REM: begin
        if (rem_found) begin
          for (int j = 0; j < NUM_VOICES - 1; j++) begin
            if (VIDX_W'(j) >= rem_idx) begin
              held_stack_nxt[j] = held_stack_r[j+1];
            end
          end
          held_count_nxt = held_count_r - CNT_W'(1);
        end
      end

      // push onto the stack, trigger or retarget voice 0
      ST_MONO_ON: begin
        emit_voice  = '0;
        emit_note   = note_r;
        emit_vel    = vel_r;
        emit_action = was_empty_r ? ACT_TRIGGER : (glide_enable_r ? ACT_GLIDE : ACT_SNAP);
        if (can_emit) begin
          emit = 1'b1;
          if (held_count_r >= CNT_W'(NUM_VOICES)) begin
            for (int j = 0; j < NUM_VOICES - 1; j++) begin
              held_stack_nxt[j] = held_stack_r[j+1];
            end
            held_stack_nxt[NUM_VOICES-1] = note_r;
            held_count_nxt               = CNT_W'(NUM_VOICES);
          end else begin
            held_stack_nxt[VIDX_W'(held_count_r)] = note_r;
            held_count_nxt = held_count_r + CNT_W'(1);
          end
          mono_vel_nxt      = vel_r;
          voice_note_nxt[0] = note_r;
          if (was_empty_r) begin
            voice_busy_nxt[0] = 1'b1;
            voice_age_nxt[0]  = next_age_r;
            next_age_nxt      = next_age_r + AGE_W'(1);
          end
        end
      end

      // release voice 0 or fall back to the newest held note
      ST_MONO_OFF: begin
        emit_voice = '0;
        if (held_count_r == '0) begin
          emit_action = ACT_RELEASE;
        end else begin
          emit_action = glide_enable_r ? ACT_GLIDE : ACT_SNAP;
          emit_note   = stack_top;
          emit_vel    = mono_vel_r;
        end
        if (note0_hit && can_emit) begin
          emit = 1'b1;
          if (held_count_r != '0) begin
            voice_note_nxt[0] = stack_top;
          end
        end
      end

      default: ;
    endcase
  end

  // output register handoff
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = out_action_r;
  assign out_ch.voice        = out_voice_r;
  assign out_ch.note_out     = out_note_r;
  assign out_ch.velocity_out = out_vel_r;
  assign out_ch.last         = out_last_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      mono_legato_r  <= 1'b0;
      glide_enable_r <= 1'b0;
      voice_busy_r   <= '0;
      next_age_r     <= '0;
      held_count_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      voice_busy_r <= voice_busy_nxt;
      next_age_r   <= next_age_nxt;
      held_count_r <= held_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MONO_LEGATO:  mono_legato_r  <= cfg_wdata[0];
          REG_GLIDE_ENABLE: glide_enable_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    voice_note_r <= voice_note_nxt;
    voice_age_r  <= voice_age_nxt;
    held_stack_r <= held_stack_nxt;
    mono_vel_r   <= mono_vel_nxt;
    func_r       <= func_nxt;
    note_r       <= note_nxt;
    vel_r        <= vel_nxt;
    scan_idx_r   <= scan_idx_nxt;
    pick_r       <= pick_nxt;
    best_age_r   <= best_age_nxt;
    mask_r       <= mask_nxt;
    mono_tail_r  <= mono_tail_nxt;
    mono_emit_r  <= mono_emit_nxt;
    was_empty_r  <= was_empty_nxt;
    if (emit) begin
      out_action_r <= emit_action;
      out_voice_r  <= emit_voice;
      out_note_r   <= emit_note;
      out_vel_r    <= emit_vel;
      out_last_r   <= emit_last;
    end
  end

  // checks
  a_held_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= CNT_W'(NUM_VOICES))
    else $error("held stack count above depth");

  a_steal_all_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEAL |-> &voice_busy_r[NUM_VOICES-1:1])
    else $error("steal search with a free voice");

  a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_action == ACT_TRIGGER) |=> next_age_r == $past(next_age_r) + AGE_W'(1))
    else $error("age counter not advanced on trigger");

  a_busy_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func != FUNC_VOICE_DONE) |=> !in_ch.ready)
    else $error("ready while an event is in work");

  a_emit_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> can_emit)
    else $error("command overwrites an untaken result");

endmodule

/* sim/synth_voice_allocator_unit_test.sv */
// testbench for the voice allocator: note event stimulus, voice command prediction and check
module synth_voice_allocator_unit_test;
  import sva_pkg::*;

  localparam int MAX_CMDS    = 8;
  localparam int TAIL_CYCLES = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    func_t             fn;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [2:0]        vidx;
  } note_event_t;

  typedef struct packed {
    action_t           action;
    logic [2:0]        voice;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              last;
  } voice_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sva_in_if  in_ch ();
  sva_out_if out_ch ();

  synth_voice_allocator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // stimulus and expected command stores
  note_event_t       note_events[$];
  voice_cmd_t        voice_cmds_due[$];
  voice_cmd_t        event_cmds[$];
  logic [NOTE_W-1:0] keys_down[$];

  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int cycle_count;

  // allocator state as the testbench sees it
  bit                mono_mode;
  bit                glide_mode;
  bit                v_busy[NUM_VOICES];
  logic [NOTE_W-1:0] v_note[NUM_VOICES];
  logic [AGE_W-1:0]  v_age[NUM_VOICES];
  logic [AGE_W-1:0]  age_count;
  logic [NOTE_W-1:0] held_notes[NUM_VOICES];
  int                held_cnt;
  logic [VEL_W-1:0]  mono_vel;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one command of the current event, extra ones are dropped
  function automatic void add_cmd(input action_t act, input int v,
                                  input logic [NOTE_W-1:0] nt, input logic [VEL_W-1:0] vel);
    voice_cmd_t c;
    if (event_cmds.size() < MAX_CMDS) begin
      c.action = act;
      c.voice  = 3'(v);
      c.note   = nt;
      c.vel    = vel;
      c.last   = 1'b0;
      event_cmds.push_back(c);
    end
  endfunction

  // take a note out of the held stack, closing the gap
  function automatic void drop_held(input logic [NOTE_W-1:0] nt);
    int pos;
    int i;
    pos = -1;
    for (i = 0; i < held_cnt; i++)
      if (pos < 0 && held_notes[i] == nt) pos = i;
    if (pos >= 0) begin
      for (i = pos; i + 1 < held_cnt; i++) held_notes[i] = held_notes[i + 1];
      held_cnt--;
    end
  endfunction

  // work out the voice commands one note event causes
  function automatic void allocate_event(input func_t fn, input logic [NOTE_W-1:0] nt,
                                         input logic [VEL_W-1:0] vel, input logic [2:0] vidx);
    func_t             f;
    int                pick;
    int                i;
    bit                was_empty;
    logic [NOTE_W-1:0] top;
    f = fn;
    event_cmds.delete();
    // zero velocity note on counts as note off
    if (f == FUNC_NOTE_ON && vel == '0) f = FUNC_NOTE_OFF;
    case (f)
      FUNC_NOTE_ON: begin
        if (mono_mode) begin
          was_empty = (held_cnt == 0);
          drop_held(nt);
          // full stack loses its oldest note
          if (held_cnt >= NUM_VOICES) begin
            for (i = 0; i + 1 < NUM_VOICES; i++) held_notes[i] = held_notes[i + 1];
            held_cnt = NUM_VOICES - 1;
          end
          held_notes[held_cnt] = nt;
          held_cnt++;
          mono_vel  = vel;
          v_note[0] = nt;
          if (was_empty) begin
            v_busy[0] = 1'b1;
            v_age[0]  = age_count;
            age_count = age_count + 1;
            add_cmd(ACT_TRIGGER, 0, nt, vel);
          end else begin
            add_cmd(glide_mode ? ACT_GLIDE : ACT_SNAP, 0, nt, vel);
          end
        end else begin
          pick = 0;
          for (i = 1; i < NUM_VOICES; i++)
            if (pick == 0 && !v_busy[i]) pick = i;
          // no free voice: steal the oldest trigger, lowest index on a tie
          if (pick == 0) begin
            pick = 1;
            for (i = 2; i < NUM_VOICES; i++)
              if (v_age[i] < v_age[pick]) pick = i;
          end
          v_busy[pick] = 1'b1;
          v_note[pick] = nt;
          v_age[pick]  = age_count;
          age_count    = age_count + 1;
          add_cmd(ACT_TRIGGER, pick, nt, vel);
        end
      end
      FUNC_NOTE_OFF: begin
        for (i = 1; i < NUM_VOICES; i++)
          if (v_busy[i] && v_note[i] == nt) add_cmd(ACT_RELEASE, i, '0, '0);
        // mono stack update, fall back to the newest held note
        if (held_cnt > 0 || (v_busy[0] && v_note[0] == nt)) begin
          drop_held(nt);
          if (v_note[0] == nt) begin
            if (held_cnt == 0) begin
              add_cmd(ACT_RELEASE, 0, '0, '0);
            end else begin
              top       = held_notes[held_cnt - 1];
              v_note[0] = top;
              add_cmd(glide_mode ? ACT_GLIDE : ACT_SNAP, 0, top, mono_vel);
            end
          end
        end
      end
      FUNC_ALL_OFF: begin
        for (i = 0; i < NUM_VOICES; i++)
          if (v_busy[i]) add_cmd(ACT_RELEASE, i, '0, '0);
        held_cnt = 0;
      end
      default: begin
        if (vidx < NUM_VOICES) v_busy[vidx] = 1'b0;
      end
    endcase
    if (event_cmds.size() > 0) event_cmds[event_cmds.size() - 1].last = 1'b1;
    foreach (event_cmds[k]) voice_cmds_due.push_back(event_cmds[k]);
  endfunction

  // mismatch accounting, only the first ten are shown
  task automatic report_bad(input bit have_want, input voice_cmd_t want);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want)
        $display("mismatch: expected act %0d voice %0d note %0d vel %0d last %0d, got act %0d voice %0d note %0d vel %0d last %0d",
                 want.action, want.voice, want.note, want.vel, want.last, out_ch.action,
                 out_ch.voice, out_ch.note_out, out_ch.velocity_out, out_ch.last);
      else
        $display("unexpected command: act %0d voice %0d note %0d vel %0d last %0d",
                 out_ch.action, out_ch.voice, out_ch.note_out, out_ch.velocity_out, out_ch.last);
    end
  endtask

  // input driver: next transaction once the current one is taken
  always @(posedge clk) begin : drive_events
    note_event_t ev;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (note_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        ev = note_events.pop_front();
        in_ch.func        <= ev.fn;
        in_ch.note        <= ev.note;
        in_ch.velocity    <= ev.vel;
        in_ch.voice_index <= ev.vidx;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output back pressure
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin : watch_channels
    voice_cmd_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        allocate_event(func_t'(in_ch.func), in_ch.note, in_ch.velocity, in_ch.voice_index);
      if (out_ch.valid && out_ch.ready) begin
        if (voice_cmds_due.size() == 0) begin
          want = '0;
          report_bad(1'b0, want);
        end else begin
          want = voice_cmds_due.pop_front();
          if (out_ch.action != want.action || out_ch.voice != want.voice ||
              out_ch.note_out != want.note || out_ch.velocity_out != want.vel ||
              out_ch.last != want.last)
            report_bad(1'b1, want);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_event(input func_t fn, input int nt, input int vel, input int vidx);
    note_event_t ev;
    ev.fn   = fn;
    ev.note = NOTE_W'(nt);
    ev.vel  = VEL_W'(vel);
    ev.vidx = 3'(vidx);
    note_events.push_back(ev);
  endtask

  // wait until all events are taken and all commands are back, then let the block settle
  task automatic wait_quiet();
    do @(posedge clk);
    while (note_events.size() != 0 || in_ch.valid || voice_cmds_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // register writes, only while the block is idle
  task automatic set_config(input bit mono, input bit glide);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MONO_LEGATO;
    cfg_wdata <= mono;
    @(posedge clk);
    cfg_index <= REG_GLIDE_ENABLE;
    cfg_wdata <= glide;
    @(posedge clk);
    cfg_we     <= 1'b0;
    mono_mode  = mono;
    glide_mode = glide;
  endtask

  // random phase: mostly playable key sequences with random content
  task automatic random_phase(input bit mono, input bit glide, input int send_pct,
                              input int stall, input int count);
    int                r;
    int                k;
    logic [NOTE_W-1:0] nt;
    send_idle_pct = send_pct;
    stall_pct     = stall;
    set_config(mono, glide);
    repeat (count) begin
      r = $urandom_range(99);
      if (keys_down.size() > 10) r = 60;
      if (r < 48) begin
        // note on, sometimes a key already down
        if (keys_down.size() != 0 && $urandom_range(3) == 0)
          nt = keys_down[$urandom_range(keys_down.size() - 1)];
        else
          nt = $urandom_range(127);
        push_event(FUNC_NOTE_ON, nt, $urandom_range(127, 1), $urandom_range(7));
        keys_down.push_back(nt);
      end else if (r < 82) begin
        // note off, or zero velocity note on, mostly of a key that is down
        if (keys_down.size() != 0 && $urandom_range(6) != 0) begin
          k  = $urandom_range(keys_down.size() - 1);
          nt = keys_down[k];
          keys_down.delete(k);
        end else begin
          nt = $urandom_range(127);
        end
        if (r < 54)
          push_event(FUNC_NOTE_ON, nt, 0, $urandom_range(7));
        else
          push_event(FUNC_NOTE_OFF, nt, $urandom_range(127), $urandom_range(7));
      end else if (r < 86) begin
        push_event(FUNC_ALL_OFF, $urandom_range(127), $urandom_range(127), $urandom_range(7));
        keys_down.delete();
      end else begin
        push_event(FUNC_VOICE_DONE, $urandom_range(127), $urandom_range(127),
                   $urandom_range(7));
      end
    end
    wait_quiet();
  endtask

  // main sequence
  initial begin
    int n;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_NOTE_ON;
    in_ch.note        = '0;
    in_ch.velocity    = '0;
    in_ch.voice_index = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    mismatches        = 0;
    cycle_count       = 0;
    mono_mode         = 1'b0;
    glide_mode        = 1'b0;
    age_count         = '0;
    held_cnt          = 0;
    mono_vel          = '0;
    for (n = 0; n < NUM_VOICES; n++) begin
      v_busy[n]     = 1'b0;
      v_note[n]     = '0;
      v_age[n]      = '0;
      held_notes[n] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // poly: extremes, fill all voices, steal, shared note off, zero velocity, voice done
    set_config(1'b0, 1'b0);
    push_event(FUNC_NOTE_ON, 0, 127, 0);
    push_event(FUNC_NOTE_ON, 127, 1, 7);
    push_event(FUNC_NOTE_ON, 60, 64, 0);
    push_event(FUNC_NOTE_ON, 60, 100, 0);
    push_event(FUNC_NOTE_ON, 61, 85, 0);
    push_event(FUNC_NOTE_ON, 62, 42, 0);
    push_event(FUNC_NOTE_ON, 63, 10, 0);
    push_event(FUNC_NOTE_ON, 64, 90, 0);
    push_event(FUNC_NOTE_OFF, 60, 0, 0);
    push_event(FUNC_NOTE_ON, 60, 0, 0);
    push_event(FUNC_VOICE_DONE, 0, 0, 2);
    push_event(FUNC_ALL_OFF, 0, 0, 0);
    wait_quiet();

    // mono: trigger, retarget, duplicate, fall back, idle voice 0 cases, full stack
    set_config(1'b1, 1'b0);
    push_event(FUNC_NOTE_ON, 70, 50, 0);
    push_event(FUNC_NOTE_ON, 72, 60, 0);
    push_event(FUNC_NOTE_ON, 70, 70, 0);
    push_event(FUNC_NOTE_OFF, 70, 0, 0);
    push_event(FUNC_VOICE_DONE, 0, 0, 0);
    push_event(FUNC_NOTE_ON, 74, 20, 0);
    push_event(FUNC_NOTE_OFF, 74, 0, 0);
    push_event(FUNC_NOTE_OFF, 72, 0, 0);
    for (n = 0; n < NUM_VOICES + 1; n++) push_event(FUNC_NOTE_ON, 100 + n, 30 + n, 0);
    push_event(FUNC_ALL_OFF, 0, 0, 0);
    wait_quiet();

    // random phases over settings and idling patterns
    random_phase(1'b0, 1'b0, 0, 0, 45);
    random_phase(1'b1, 1'b0, 84, 0, 45);
    random_phase(1'b1, 1'b1, 0, 84, 45);
    random_phase(1'b0, 1'b1, 17, 17, 45);
    // sender holds off until every command of the first half is back
    random_phase(1'b1, 1'b1, 0, 0, 25);
    random_phase(1'b1, 1'b1, 0, 0, 25);
    random_phase(1'b0, 1'b0, 17, 17, 50);

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
